/* design/mqsb_pkg.sv */
// Package with shared types, constants and helpers for the multi-queue shared buffer.
`default_nettype none
package mqsb_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int NUM_QUEUES = 4;

  localparam int ADDR_W = $clog2(NUM_SLOTS);
  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int DATA_W = 32;
  localparam int QID_W  = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam ptr_t NULL_PTR = ptr_t'(NUM_SLOTS);

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic               mode;
    logic [QID_W-1:0]   queue_id;
    logic signed [31:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    ptr_t  wr_data;
  } link_req_t;

  function automatic logic is_slot(ptr_t p);
    return p < NULL_PTR;
  endfunction

endpackage
`default_nettype wire

/* design/multi_queue_shared_buffer.sv */
// Top level: several FIFO queues sharing one slot buffer through a linked free list.
//
// A command word (enqueue or dequeue, queue number, data) is taken at a rising
// edge where start is high and busy is low. The word is registered, the link
// table and the data buffer are read in the following cycle, and in the cycle
// after that the pointers and the link table are updated. The response word
// (data and status) is registered at the end of that update cycle, is shown
// on result for exactly one cycle with done high, and is taken while done is high.
// A new command can be taken in the update cycle of the one before it; busy is
// high for the one cycle in which the memory reads are in flight, since each
// update reads the link table at a registered pointer and writes it in the next cycle.
// Status is ok, full when no slot is free, or empty when the queue holds no
// word; data is zero unless a dequeue succeeds.
// Reset empties every queue and chains all slots onto the free list at once,
// with no clearing pass; busy is high while reset is applied.
// The receiver cannot stall: each response must be taken in its done cycle.
`default_nettype none
module multi_queue_shared_buffer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire mqsb_pkg::cmd_t item,
  output logic                done,
  output mqsb_pkg::rsp_t      result
);
  import mqsb_pkg::*;

  state_t    state;
  state_t    state_next;
  cmd_t      cmd_q;
  ptr_t      head [NUM_QUEUES];
  ptr_t      tail [NUM_QUEUES];
  ptr_t      free_head;
  logic      accept;
  logic      q_ok;
  ptr_t      head_sel;
  ptr_t      tail_sel;
  ptr_t      link_rd;
  ptr_t      deq_next;
  logic      enq_ok;
  logic      deq_ok;
  rsp_t      res_next;
  link_req_t link_req;
  logic [DATA_W-1:0] data_rd;

  assign busy   = rst || (state == S_LOOK);
  assign accept = start && !busy;

  mqsb_link_store u_link (
    .clk    (clk),
    .rst    (rst),
    .req    (link_req),
    .rd_link(link_rd)
  );

  mqsb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_SLOTS)
  ) u_data (
    .clk    (clk),
    .wr_en  ((state == S_EXEC) && enq_ok),
    .wr_addr(free_head[ADDR_W-1:0]),
    .wr_data(cmd_q.data_in),
    .rd_en  (state == S_LOOK),
    .rd_addr(head_sel[ADDR_W-1:0]),
    .rd_data(data_rd)
  );

  always_comb begin
    q_ok     = int'(cmd_q.queue_id) < NUM_QUEUES;
    head_sel = q_ok ? head[cmd_q.queue_id] : NULL_PTR;
    tail_sel = q_ok ? tail[cmd_q.queue_id] : NULL_PTR;
    enq_ok   = (cmd_q.mode == MODE_ENQ) && q_ok && is_slot(free_head);
    deq_ok   = (cmd_q.mode == MODE_DEQ) && is_slot(head_sel);
    // The tail's own link is never kept current, so the last word ends the chain.
    deq_next = (head_sel == tail_sel || !is_slot(link_rd)) ? NULL_PTR : link_rd;

    link_req.rd_en   = (state == S_LOOK);
    link_req.rd_addr = (cmd_q.mode == MODE_ENQ) ? free_head[ADDR_W-1:0]
                                                : head_sel[ADDR_W-1:0];
    link_req.wr_en   = 1'b0;
    link_req.wr_addr = head_sel[ADDR_W-1:0];
    link_req.wr_data = free_head;
    if (state == S_EXEC) begin
      if (enq_ok && is_slot(head_sel) && is_slot(tail_sel)) begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = tail_sel[ADDR_W-1:0];
      end else if (deq_ok) begin
        link_req.wr_en = 1'b1;
      end
    end

    res_next.data_out = deq_ok ? data_rd : '0;
    if (cmd_q.mode == MODE_ENQ) begin
      res_next.status = enq_ok ? ST_OK : ST_FULL;
    end else begin
      res_next.status = deq_ok ? ST_OK : ST_EMPTY;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOOK;
      S_LOOK: state_next = S_EXEC;
      S_EXEC: state_next = accept ? S_LOOK : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      free_head <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= NULL_PTR;
        tail[i] <= NULL_PTR;
      end
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (state == S_EXEC) begin
        if (enq_ok) begin
          free_head <= link_rd;
          if (!is_slot(head_sel)) begin
            head[cmd_q.queue_id] <= free_head;
          end
          tail[cmd_q.queue_id] <= free_head;
        end else if (deq_ok) begin
          free_head            <= head_sel;
          head[cmd_q.queue_id] <= deq_next;
          if (!is_slot(deq_next)) begin
            tail[cmd_q.queue_id] <= NULL_PTR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= item;
    end
    if (state == S_EXEC) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

/* design/mqsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/mqsb_link_store.sv */
// Link table: next-pointer RAM with per-entry valid bits that supply the reset chain.
`default_nettype none
module mqsb_link_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mqsb_pkg::link_req_t req,
  output mqsb_pkg::ptr_t           rd_link
);
  import mqsb_pkg::*;

  logic [NUM_SLOTS-1:0] valid;
  logic                 rd_valid;
  addr_t                rd_addr_q;
  ptr_t                 ram_data;

  mqsb_ram #(
    .WIDTH(PTR_W),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (req.wr_en),
    .wr_addr(req.wr_addr),
    .wr_data(req.wr_data),
    .rd_en  (req.rd_en),
    .rd_addr(req.rd_addr),
    .rd_data(ram_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid  <= valid[req.rd_addr];
      rd_addr_q <= req.rd_addr;
    end
  end

  // An entry never written still holds its reset link to the following slot.
  assign rd_link = rd_valid ? ram_data : ptr_t'(rd_addr_q) + ptr_t'(1);

endmodule
`default_nettype wire

/* design/mqsb_checker.sv */
// Port-level checker for the multi-queue shared buffer and its bind statement.
`default_nettype none
module mqsb_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire mqsb_pkg::rsp_t result
);
  import mqsb_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after a command word was taken");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##2 done)
    else $error("response word did not appear three cycles after its command");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy stayed high for more than one cycle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done was high in two consecutive cycles");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> result.data_out == '0)
    else $error("failed operation returned nonzero data");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
`default_nettype wire
